// ===== rtl/ptc_pkg.sv =====
// shared types and constants for the pressure and temperature compensation block
package ptc_pkg;

  localparam int unsigned DivCells = 64;

  typedef enum logic [1:0] {
    CFG_TEMP    = 2'd0,
    CFG_PRESS_A = 2'd1,
    CFG_PRESS_B = 2'd2,
    CFG_PRESS_C = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
  } cal_t;

  typedef struct packed {
    logic        valid;
    logic [63:0] nq;
    logic [30:0] rem;
    logic [30:0] den;
    logic        neg;
    logic        invalid;
    logic [31:0] temp;
  } div_t;

endpackage

// ===== rtl/ptc_div_cell.sv =====
// one restoring division cell: resolves one quotient bit per beat
module ptc_div_cell
  import ptc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  div_t d_i,
  output div_t q_o
);

  logic [31:0] trial;
  logic        ge;
  logic [31:0] diff;
  div_t        q_d, q_q;

  always_comb begin
    trial = {d_i.rem, d_i.nq[63]};
    ge    = trial >= {1'b0, d_i.den};
    diff  = trial - {1'b0, d_i.den};
    q_d     = d_i;
    q_d.nq  = {d_i.nq[62:0], ge};
    q_d.rem = ge ? diff[30:0] : trial[30:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q <= '0;
    end else if (en_i) begin
      q_q <= q_d;
    end
  end

  assign q_o = q_q;

endmodule

// ===== rtl/ptc_front.sv =====
// temperature path and pressure dividend and divisor ahead of the divider chain
module ptc_front
  import ptc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [19:0] raw_t_i,
  input  logic [19:0] raw_p_i,
  input  cal_t        cal_i,
  output div_t        div_o
);

  logic [9:0] vld_q;
  logic [31:0] x1_q, dd0_q, temp_e_q, temp_f_q, temp_g_q, temp_h_q, temp_i_q, temp_j_q;
  logic signed [31:0] m1_q, dd_q, a_q, e_q, fine_q;
  logic [20:0] pr_a_q, pr_b_q, pr_c_q, pr_d_q, pr_e_q, pr_f_q, pr_g_q, pr_h_q, pr_i_q;
  logic signed [32:0] v1_q;
  logic signed [63:0] sq_q, m5_q, m2_q, a6_q, a3_q, m5g_q, m2g_q, v2_q, u_q, v2i_q, w_q;
  logic signed [63:0] num_q;
  logic signed [30:0] den_q;
  div_t out_q;

  logic [31:0] x1_d, dd0_d;
  logic signed [31:0] temp_d;
  logic signed [63:0] num_d, w_d;

  always_comb begin
    x1_d   = {15'b0, raw_t_i[19:3]} - {15'b0, cal_i.t1, 1'b0};
    dd0_d  = {16'b0, raw_t_i[19:4]} - {16'b0, cal_i.t1};
    temp_d = (fine_q * 32'sd5 + 32'sd128) >>> 8;
    w_d    = (64'sh0000_8000_0000_0000 + u_q) * $signed({1'b0, cal_i.p1});
    num_d  = (({43'b0, pr_i_q} << 31) - v2i_q) * 64'sd3125;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      out_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[8:0], valid_i};
      out_q.valid   <= vld_q[9];
      out_q.nq      <= num_q[63] ? 64'(-num_q) : num_q;
      out_q.rem     <= '0;
      out_q.den     <= den_q[30] ? 31'(-den_q) : den_q;
      out_q.neg     <= num_q[63] ^ den_q[30];
      out_q.invalid <= den_q == '0;
      out_q.temp    <= temp_j_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q   <= x1_d;
      dd0_q  <= dd0_d;
      pr_a_q <= 21'd1048576 - {1'b0, raw_p_i};
      m1_q   <= $signed(x1_q) * $signed(cal_i.t2);
      dd_q   <= $signed(dd0_q) * $signed(dd0_q);
      pr_b_q <= pr_a_q;
      a_q    <= m1_q >>> 11;
      e_q    <= (dd_q >>> 12) * $signed(cal_i.t3);
      pr_c_q <= pr_b_q;
      fine_q <= a_q + (e_q >>> 14);
      pr_d_q <= pr_c_q;
      temp_e_q <= temp_d;
      v1_q     <= 33'(fine_q) - 33'sd128000;
      pr_e_q   <= pr_d_q;
      sq_q     <= v1_q * v1_q;
      m5_q     <= v1_q * $signed(cal_i.p5);
      m2_q     <= v1_q * $signed(cal_i.p2);
      temp_f_q <= temp_e_q;
      pr_f_q   <= pr_e_q;
      a6_q     <= sq_q * $signed(cal_i.p6);
      a3_q     <= sq_q * $signed(cal_i.p3);
      m5g_q    <= m5_q;
      m2g_q    <= m2_q;
      temp_g_q <= temp_f_q;
      pr_g_q   <= pr_f_q;
      v2_q     <= a6_q + (m5g_q <<< 17) + (64'($signed(cal_i.p4)) <<< 35);
      u_q      <= (a3_q >>> 8) + (m2g_q <<< 12);
      temp_h_q <= temp_g_q;
      pr_h_q   <= pr_g_q;
      w_q      <= w_d;
      v2i_q    <= v2_q;
      temp_i_q <= temp_h_q;
      pr_i_q   <= pr_h_q;
      den_q    <= 31'(w_q >>> 33);
      num_q    <= num_d;
      temp_j_q <= temp_i_q;
    end
  end

  assign div_o = out_q;

endmodule

// ===== rtl/ptc_back.sv =====
// sign fix of the quotient, second-order pressure terms and output register
module ptc_back
  import ptc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  div_t        div_i,
  input  cal_t        cal_i,
  output logic        valid_o,
  output logic [31:0] temp_o,
  output logic [31:0] press_o,
  output logic        invalid_o
);

  logic [4:0] vld_q;
  logic signed [63:0] q_q, qm_q, qn_q, qo_q, ll_q, m8_q, sq2_q, w2_q, w2o_q, w1_q;
  logic [31:0] hl_q;
  logic [31:0] t_l_q, t_m_q, t_n_q, t_o_q, temp_q, press_q;
  logic inv_l_q, inv_m_q, inv_n_q, inv_o_q, invalid_q;
  logic signed [63:0] ps, res;

  always_comb begin
    ps  = q_q >>> 13;
    res = ((qo_q + w1_q + w2o_q) >>> 8) + (64'($signed(cal_i.p7)) <<< 4);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], div_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q     <= div_i.neg ? 64'(-div_i.nq) : div_i.nq;
      t_l_q   <= div_i.temp;
      inv_l_q <= div_i.invalid;
      ll_q    <= $signed({32'b0, ps[31:0]} * {32'b0, ps[31:0]});
      hl_q    <= ps[63:32] * ps[31:0];
      m8_q    <= q_q * $signed(cal_i.p8);
      qm_q    <= q_q;
      t_m_q   <= t_l_q;
      inv_m_q <= inv_l_q;
      sq2_q   <= ll_q + $signed({hl_q[30:0], 33'b0});
      w2_q    <= m8_q >>> 19;
      qn_q    <= qm_q;
      t_n_q   <= t_m_q;
      inv_n_q <= inv_m_q;
      w1_q    <= (sq2_q * $signed(cal_i.p9)) >>> 25;
      w2o_q   <= w2_q;
      qo_q    <= qn_q;
      t_o_q   <= t_n_q;
      inv_o_q <= inv_n_q;
      temp_q    <= t_o_q;
      press_q   <= inv_o_q ? 32'd0 : res[31:0];
      invalid_q <= inv_o_q;
    end
  end

  assign valid_o   = vld_q[4];
  assign temp_o    = temp_q;
  assign press_o   = press_q;
  assign invalid_o = invalid_q;

endmodule

// ===== rtl/pressure_temperature_compensation.sv =====
// top level: calibration registers, front stages, divider cell chain and back stages
// Takes one raw temperature and pressure pair per clock and returns one
// compensated result per clock, in order, while the output is not stalled.
// The pipeline is the 64-cell division chain, which resolves one quotient
// bit per cell, plus 11 front and 5 back stages. A stall on the output
// holds the whole pipeline. Calibration writes are always taken and must
// only happen while no item is in flight.
module pressure_temperature_compensation
  import ptc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [19:0] raw_temperature_i,
  input  logic [19:0] raw_pressure_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [31:0] temperature_centi_o,
  output logic [31:0] pressure_q24_8_o,
  output logic        pressure_invalid_o
);

  logic [47:0] temp_cal_q, pa_cal_q, pb_cal_q, pc_cal_q;
  cal_t cal;
  logic en;
  div_t chain [DivCells+1];
  logic [31:0] temp_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_cal_q <= '0;
      pa_cal_q   <= '0;
      pb_cal_q   <= '0;
      pc_cal_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_TEMP:    temp_cal_q <= cfg_data_i;
        CFG_PRESS_A: pa_cal_q   <= cfg_data_i;
        CFG_PRESS_B: pb_cal_q   <= cfg_data_i;
        CFG_PRESS_C: pc_cal_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cal = '{t1: temp_cal_q[15:0], t2: temp_cal_q[31:16], t3: temp_cal_q[47:32],
                 p1: pa_cal_q[15:0],   p2: pa_cal_q[31:16],   p3: pa_cal_q[47:32],
                 p4: pb_cal_q[15:0],   p5: pb_cal_q[31:16],   p6: pb_cal_q[47:32],
                 p7: pc_cal_q[15:0],   p8: pc_cal_q[31:16],   p9: pc_cal_q[47:32]};

  assign cfg_ready_o = 1'b1;
  assign en          = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !en;

  ptc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .raw_t_i (raw_temperature_i),
    .raw_p_i (raw_pressure_i),
    .cal_i   (cal),
    .div_o   (chain[0])
  );

  for (genvar i = 0; i < DivCells; i++) begin : g_cell
    ptc_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .d_i    (chain[i]),
      .q_o    (chain[i+1])
    );
  end

  ptc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .div_i     (chain[DivCells]),
    .cal_i     (cal),
    .valid_o   (out_valid_o),
    .temp_o    (temp_out),
    .press_o   (pressure_q24_8_o),
    .invalid_o (pressure_invalid_o)
  );

  assign temperature_centi_o = $signed(temp_out);

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pressure_invalid_o |-> pressure_q24_8_o == 32'd0)
    else $error("invalid pressure beat carries nonzero pressure");

  a_cfg_temp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_index_i == CFG_TEMP |=> temp_cal_q == $past(cfg_data_i))
    else $error("temperature calibration write lost");

  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

endmodule

// ===== tb/tb_top.sv =====
// testbench for the pressure and temperature compensation block with its own integer predictor
module tb_top;
  import ptc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] temp;
    logic [31:0]        press;
    logic               invalid;
  } reading_t;

  typedef struct packed {
    logic [19:0] raw_t;
    logic [19:0] raw_p;
  } sample_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [47:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [19:0] raw_temperature_i = '0;
  logic [19:0] raw_pressure_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic signed [31:0] temperature_centi_o;
  logic [31:0] pressure_q24_8_o;
  logic        pressure_invalid_o;

  cal_t     cal_words = '0;
  sample_t  pending_samples[$];
  reading_t expected_readings[$];
  int       mismatches = 0;
  int       burst_left = 0;
  int       gap_left = 0;
  int       hold_cycles = 0;
  int       stall_mode = 0;
  int       mode_cycles = 0;

  pressure_temperature_compensation dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [63:0] div_trunc(logic [63:0] num, logic [63:0] den);
    logic [63:0] mn;
    logic [63:0] md;
    logic [63:0] q;
    mn = num[63] ? -num : num;
    md = den[63] ? -den : den;
    q = mn / md;
    return (num[63] != den[63]) ? -q : q;
  endfunction

  function automatic logic [63:0] sx64(logic [15:0] w);
    return {{48{w[15]}}, w};
  endfunction

  function automatic reading_t compensate(cal_t c, sample_t s);
    reading_t r;
    logic [31:0] adc, t1, t2, t3, x, a, d, b, fine;
    logic [63:0] v1, v2, y, z, p, ps, w1, w2;
    adc = {12'b0, s.raw_t};
    t1 = {16'b0, c.t1};
    t2 = {{16{c.t2[15]}}, c.t2};
    t3 = {{16{c.t3[15]}}, c.t3};
    x = ((adc >> 3) - (t1 << 1)) * t2;
    a = $signed(x) >>> 11;
    d = (adc >> 4) - t1;
    x = d * d;
    x = $signed(x) >>> 12;
    x = x * t3;
    b = $signed(x) >>> 14;
    fine = a + b;
    x = fine * 32'd5 + 32'd128;
    r.temp = $signed(x) >>> 8;

    v1 = {{32{fine[31]}}, fine} - 64'd128000;
    v2 = v1 * v1 * sx64(c.p6);
    v2 = v2 + ((v1 * sx64(c.p5)) << 17);
    v2 = v2 + (sx64(c.p4) << 35);
    y = v1 * v1 * sx64(c.p3);
    y = $signed(y) >>> 8;
    z = v1 * sx64(c.p2);
    v1 = y + (z << 12);
    y = ((64'd1 << 47) + v1) * {48'b0, c.p1};
    v1 = $signed(y) >>> 33;
    r.press = '0;
    r.invalid = 1'b0;
    if (v1 == 64'd0) begin
      r.invalid = 1'b1;
    end else begin
      p = 64'd1048576 - {44'b0, s.raw_p};
      p = div_trunc(((p << 31) - v2) * 64'd3125, v1);
      ps = $signed(p) >>> 13;
      w1 = sx64(c.p9) * ps * ps;
      w1 = $signed(w1) >>> 25;
      w2 = sx64(c.p8) * p;
      w2 = $signed(w2) >>> 19;
      y = p + w1 + w2;
      y = $signed(y) >>> 8;
      y = y + (sx64(c.p7) << 4);
      r.press = y[31:0];
    end
    return r;
  endfunction

  // sender: bursts with random gaps
  always @(posedge clk_i) begin
    if (!in_valid_i || !in_stall_o) begin
      if (in_valid_i) begin
        expected_readings.push_back(compensate(cal_words, {raw_temperature_i, raw_pressure_i}));
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        sample_t s;
        s = pending_samples.pop_front();
        in_valid_i <= 1'b1;
        raw_temperature_i <= s.raw_t;
        raw_pressure_i <= s.raw_p;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(40, 1);
          gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver stall pattern, with one long hold-off
  always @(posedge clk_i) begin
    if (mode_cycles == 0) begin
      stall_mode <= $urandom_range(3);
      mode_cycles <= $urandom_range(120, 20);
    end else begin
      mode_cycles <= mode_cycles - 1;
    end
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(3) == 0);
        2: out_stall_i <= ($urandom_range(9) < 7);
        default: out_stall_i <= mode_cycles[2];
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (expected_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat at %0t", $realtime);
      end else begin
        reading_t e;
        e = expected_readings.pop_front();
        if (e.temp !== temperature_centi_o || e.press !== pressure_q24_8_o
            || e.invalid !== pressure_invalid_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: expected t=%0d p=%h inv=%b, got t=%0d p=%h inv=%b",
                     $realtime, e.temp, e.press, e.invalid, temperature_centi_o,
                     pressure_q24_8_o, pressure_invalid_o);
        end
      end
    end
  end

  task automatic write_cal(cfg_reg_e idx, logic [47:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_TEMP:    {cal_words.t3, cal_words.t2, cal_words.t1} = data;
      CFG_PRESS_A: {cal_words.p3, cal_words.p2, cal_words.p1} = data;
      CFG_PRESS_B: {cal_words.p6, cal_words.p5, cal_words.p4} = data;
      default:     {cal_words.p9, cal_words.p8, cal_words.p7} = data;
    endcase
  endtask

  task automatic load_cal(logic [47:0] t, logic [47:0] pa, logic [47:0] pb, logic [47:0] pc);
    write_cal(CFG_TEMP, t);
    write_cal(CFG_PRESS_A, pa);
    write_cal(CFG_PRESS_B, pb);
    write_cal(CFG_PRESS_C, pc);
  endtask

  function automatic logic [47:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  task automatic queue_random(int n);
    sample_t s;
    repeat (n) begin
      if ($urandom_range(9) < 6) begin
        s.raw_t = 20'($urandom);
        s.raw_p = 20'($urandom);
      end else begin
        s.raw_t = 20'($urandom_range(600000, 400000));
        s.raw_p = 20'($urandom_range(500000, 200000));
      end
      pending_samples.push_back(s);
    end
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (pending_samples.size() != 0 || in_valid_i || expected_readings.size() != 0);
    repeat (100) @(posedge clk_i);
  endtask

  localparam logic [47:0] TypT  = {16'hfc18, 16'd26435, 16'd27504};
  localparam logic [47:0] TypPA = {16'd3024, 16'hd643, 16'd36477};
  localparam logic [47:0] TypPB = {16'hfff9, 16'd140, 16'd2855};
  localparam logic [47:0] TypPC = {16'd6000, 16'hc6f8, 16'd15500};

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset calibration: divisor is zero
    queue_random(100);
    drain();

    load_cal('1, '1, '1, '1);
    queue_random(150);
    drain();

    load_cal(TypT, TypPA, TypPB, TypPC);
    pending_samples.push_back({20'h00000, 20'h00000});
    pending_samples.push_back({20'hfffff, 20'hfffff});
    pending_samples.push_back({20'h00000, 20'hfffff});
    pending_samples.push_back({20'hfffff, 20'h00000});
    pending_samples.push_back({20'h80000, 20'h80000});
    pending_samples.push_back({20'h7ffff, 20'h7ffff});
    pending_samples.push_back({20'd519888, 20'd415148});
    pending_samples.push_back({20'haaaaa, 20'h55555});
    pending_samples.push_back({20'h55555, 20'haaaaa});
    for (int i = 0; i < 20; i += 2) pending_samples.push_back({20'(1 << i), 20'(2 << i)});
    queue_random(300);
    hold_cycles = 400;
    drain();

    // zero p1 gives a zero divisor with real data
    load_cal(TypT, {TypPA[47:16], 16'd0}, TypPB, TypPC);
    queue_random(100);
    drain();

    load_cal({16'h7fff, 16'h8000, 16'hffff}, {16'h8000, 16'h7fff, 16'hffff},
             {16'h7fff, 16'h8000, 16'h7fff}, {16'h8000, 16'h7fff, 16'h8000});
    queue_random(150);
    drain();

    repeat (4) begin
      load_cal(rand48(), rand48(), rand48(), rand48());
      queue_random(200);
      drain();
    end

    if (mismatches == 0 && expected_readings.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_top failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ptc_pkg.sv
rtl/ptc_div_cell.sv
rtl/ptc_front.sv
rtl/ptc_back.sv
rtl/pressure_temperature_compensation.sv
tb/tb_top.sv
